### sv/gcd_lcm_unit_macros.svh
// Assertion helpers used by the unit's core module.
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GLU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GLU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/gcdlcm_pkg.sv
package gcdlcm_pkg;

  // Operand bits used by the datapath (4..32); wider port bits are ignored.
  localparam int unsigned OpW  = 32;
  localparam int unsigned CntW = $clog2(OpW);

  typedef logic [OpW-1:0]   op_t;
  typedef logic [OpW:0]     sub_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [2*OpW-1:0] prod_t;

  localparam cnt_t LastCnt = cnt_t'(OpW - 1);

  typedef struct packed {
    logic idle;
    logic done;
  } core_sts_t;

endpackage

### sv/gcd_lcm_unit.sv
// Result path: with a zero operand the sequencer goes straight to done; otherwise it strips the
// shared powers of two, reduces the odd pair (shift, subtract or swap), scales, divides and
// multiplies, then raises out_valid_o once the output register is free or being drained.
// One word is in flight; in_ready_o is high while idle, from the cycle after the result moves
// into the output register, which holds it while the next word is taken.
// Reset (rst_ni, async, active low) clears the sequencer and the output valid.
module gcd_lcm_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] gcd_value_o,
  output logic [63:0] lcm_value_o
);
  import gcdlcm_pkg::*;

  core_sts_t sts;
  logic      start, take;
  op_t       core_gcd, gcd_q;
  prod_t     core_lcm, lcm_q;
  logic      out_valid_q;

  assign in_ready_o = sts.idle;
  assign start      = in_valid_i & in_ready_o;
  // Move the result out when the output register is free or being drained.
  assign take       = sts.done & (~out_valid_q | out_ready_i);

  gcdlcm_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_a_i  (op_t'(operand_a_i)),
    .op_b_i  (op_t'(operand_b_i)),
    .take_i  (take),
    .sts_o   (sts),
    .gcd_o   (core_gcd),
    .lcm_o   (core_lcm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      gcd_q <= core_gcd;
      lcm_q <= core_lcm;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gcd_value_o = 32'(gcd_q);
  assign lcm_value_o = 64'(lcm_q);

endmodule

### sv/gcdlcm_sub.sv
module gcdlcm_sub (
  input  gcdlcm_pkg::sub_t minuend_i,
  input  gcdlcm_pkg::sub_t subtrahend_i,
  output gcdlcm_pkg::sub_t diff_o,
  output logic             borrow_o
);
  import gcdlcm_pkg::*;

  logic [OpW+1:0] full;

  assign full     = {1'b0, minuend_i} - {1'b0, subtrahend_i};
  assign diff_o   = full[OpW:0];
  assign borrow_o = full[OpW+1];

endmodule

### sv/gcdlcm_core.sv
`include "gcd_lcm_unit_macros.svh"

module gcdlcm_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  gcdlcm_pkg::op_t       op_a_i,
  input  gcdlcm_pkg::op_t       op_b_i,
  input  logic                  take_i,
  output gcdlcm_pkg::core_sts_t sts_o,
  output gcdlcm_pkg::op_t       gcd_o,
  output gcdlcm_pkg::prod_t     lcm_o
);
  import gcdlcm_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SHIFT  = 7'b0000010,
    ST_REDUCE = 7'b0000100,
    ST_SCALE  = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_MUL    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  op_t    a_q, a_d, b_q, b_d, x_q, x_d, y_q, y_d, g_q, g_d, r_q, r_d;
  cnt_t   k_q, k_d, cnt_q, cnt_d;
  prod_t  lcm_q, lcm_d;

  sub_t   sub_a, sub_b, diff;
  logic   borrow;

  // Shared subtractor: odd-pair reduction in the GCD loop, trial subtract in the divide.
  always_comb begin
    if (state_q == ST_DIV) begin
      sub_a = {r_q, a_q[OpW-1]};
      sub_b = {1'b0, g_q};
    end else begin
      sub_a = {1'b0, x_q};
      sub_b = {1'b0, y_q};
    end
  end

  gcdlcm_sub u_sub (
    .minuend_i    (sub_a),
    .subtrahend_i (sub_b),
    .diff_o       (diff),
    .borrow_o     (borrow)
  );

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    x_d     = x_q;
    y_d     = y_q;
    g_d     = g_q;
    r_d     = r_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    lcm_d   = lcm_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          a_d = op_a_i;
          b_d = op_b_i;
          x_d = op_a_i;
          y_d = op_b_i;
          k_d = '0;
          if (op_a_i == '0 || op_b_i == '0) begin
            g_d     = op_a_i | op_b_i;
            lcm_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        // Strip common factors of two.
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + cnt_t'(1);
        end else begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (diff == '0) begin
          state_d = ST_SCALE;
        end else if (!borrow) begin
          x_d = op_t'(diff[OpW-1:1]);
        end else begin
          // Swap so the larger odd value sits in x.
          x_d = y_q;
          y_d = x_q;
        end
      end
      ST_SCALE: begin
        g_d     = x_q << k_q;
        r_d     = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // Restoring divide; quotient bits shift into a_q.
        r_d   = borrow ? {r_q[OpW-2:0], a_q[OpW-1]} : diff[OpW-1:0];
        a_d   = {a_q[OpW-2:0], ~borrow};
        cnt_d = cnt_q + cnt_t'(1);
        if (cnt_q == LastCnt) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        lcm_d   = prod_t'(a_q) * prod_t'(b_q);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    x_q   <= x_d;
    y_q   <= y_d;
    g_q   <= g_d;
    r_q   <= r_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
    lcm_q <= lcm_d;
  end

  assign sts_o.idle = (state_q == ST_IDLE);
  assign sts_o.done = (state_q == ST_DONE);
  assign gcd_o      = g_q;
  assign lcm_o      = lcm_q;

  `GLU_ASSERT_NOW(a_reduce_odd, state_q == ST_REDUCE, x_q[0] || y_q[0], "both even in reduce")
  `GLU_ASSERT_NOW(a_div_rem, state_q == ST_DIV, r_q < g_q, "partial remainder not below divisor")
  `GLU_ASSERT_NOW(a_exact_div, state_q == ST_MUL, r_q == '0, "divisor leaves a remainder")

endmodule
